// ===== sv/oprp_pkg.sv =====
// shared types, constants and register indexes of the odometry path record/playback unit
// no dependencies; imported by oprp_rem, the top level and the testbench

package oprp_pkg;

	// path store geometry
	localparam int NUM_PATHS   = 8;
	localparam int PATH_BYTES  = 512;
	localparam int HALF_BYTES  = PATH_BYTES / 2;
	localparam int INDEX_WRAP  = (HALF_BYTES < 256) ? HALF_BYTES : 256;
	localparam int PATH_W      = $clog2(NUM_PATHS);
	localparam int IDX_W       = $clog2(INDEX_WRAP);
	localparam int ADDR_W      = PATH_W + IDX_W;
	localparam int STORE_DEPTH = NUM_PATHS * INDEX_WRAP;

	localparam logic [7:0] END_MARK = 8'hFF;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_DIVIDE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SCALE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FULL      = 3'd5;

	// configuration reset values
	localparam logic [15:0] RST_WINDOW_TICKS   = 16'd500;
	localparam logic [7:0]  RST_BUTTON_DIVIDE  = 8'd6;
	localparam logic [7:0]  RST_RECORD_LIMIT   = 8'd250;
	localparam logic [7:0]  RST_TURN_THRESHOLD = 8'd5;
	localparam logic [7:0]  RST_DUTY_SCALE     = 8'd45;
	localparam logic [7:0]  RST_DUTY_FULL      = 8'h8F;

	// remainder unit width
	localparam int REM_W     = 16;
	localparam int REM_CNT_W = $clog2(REM_W + 1);

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_REC  = 2'd1,
		MODE_PLAY = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		SEQ_CLEAR  = 2'd0,
		SEQ_IDLE   = 2'd1,
		SEQ_REDUCE = 2'd2,
		SEQ_MEM    = 2'd3
	} seq_t;

	typedef struct packed {
		logic             start;
		logic [REM_W-1:0] dividend;
		logic [REM_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic             done;
		logic [REM_W-1:0] remainder;
	} rem_rsp_t;

endpackage

// ===== sv/oprp_ram.sv =====
// single-port synchronous ram with registered read
// depends on nothing but its parameters

module oprp_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== sv/oprp_rem.sv =====
// iterative restoring remainder unit, one quotient bit per cycle
// depends on oprp_pkg for the request and response structs

module oprp_rem import oprp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rem_req_t req,
	output rem_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [REM_CNT_W-1:0] cnt_q;
	logic [REM_W-1:0]     rem_q;
	logic [REM_W-1:0]     shf_q;
	logic [REM_W-1:0]     div_q;
	logic [REM_W:0]       trial;
	logic [REM_W:0]       diff;
	logic [REM_W-1:0]     rem_d;

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, shf_q[REM_W-1]};
		diff  = trial - {1'b0, div_q};
		rem_d = (trial >= {1'b0, div_q}) ? diff[REM_W-1:0] : trial[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= REM_CNT_W'(REM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == REM_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			shf_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			shf_q <= {shf_q[REM_W-2:0], 1'b0};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== sv/odometry_path_record_playback_unit.sv =====
// top level of the odometry path record/playback unit: mode machine, path logic, output register
// depends on oprp_pkg, oprp_ram (two path store halves) and oprp_rem (counter realignment)

//  channel | handshake                 | content
//  tick    | tick_valid / tick_ready   | btn_record btn_choose btn_select enc_* obstacle
//  result  | res_valid / res_ready     | op_state active_path path_index duties save/erase
//  config  | cfg_we, no wait           | cfg_index selects register, cfg_wdata holds value
//
//  a tick: the transfer cycle does the mode machine and issues at most one read or write
//  to both store halves, then the SEQ_MEM state takes the read data into the duties and the
//  result register; a new tick is taken only once the result register has been loaded
//  after reset a clearing pass writes 0xff to all 2048 entries of each half
//  a write to window_ticks or button_divide realigns the counters before the next tick is taken
//  a result not taken holds the unit in its read state; no tick transfers meanwhile

module odometry_path_record_playback_unit import oprp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_wdata,
	// tick channel
	input  logic                 tick_valid,
	output logic                 tick_ready,
	input  logic                 btn_record,
	input  logic                 btn_choose,
	input  logic                 btn_select,
	input  logic                 enc_right_level,
	input  logic                 enc_left_level,
	input  logic                 obstacle,
	// result channel
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [1:0]           op_state,
	output logic [2:0]           active_path,
	output logic [7:0]           path_index,
	output logic [7:0]           right_duty,
	output logic [7:0]           left_duty,
	output logic                 save_request,
	output logic [2:0]           save_path,
	output logic                 erase_request
);

	// configuration registers
	logic [15:0] window_ticks_q;
	logic [7:0]  button_divide_q;
	logic [7:0]  record_limit_q;
	logic [7:0]  turn_threshold_q;
	logic [7:0]  duty_scale_q;
	logic [7:0]  duty_full_q;

	// control state
	seq_t              seq_q, seq_d;
	logic              dirty_q;
	logic [ADDR_W-1:0] clr_addr_q;
	mode_t             cur_mode_q, pending_mode_q;
	logic [2:0]        button_prev_q;
	logic              erase_pending_q;
	logic [7:0]        divide_count_q;
	logic [15:0]       window_count_q;
	logic [IDX_W-1:0]  step_index_q;
	logic [7:0]        right_ticks_q, left_ticks_q;
	logic [1:0]        encoder_prev_q;
	logic [PATH_W-1:0] record_slot_q, candidate_path_q, replay_path_q;
	// set when the first byte written to a path differs from the end mark
	logic [NUM_PATHS-1:0] path_used_q;

	// tick stage to read stage
	logic              play_chk_s1;
	logic              save_req_s1;
	logic [PATH_W-1:0] save_path_s1;
	logic              erase_req_s1;

	// result register
	logic        res_valid_q;
	mode_t       op_state_q;
	logic [2:0]  active_path_q;
	logic [7:0]  path_index_q;
	logic [7:0]  right_duty_q, left_duty_q;
	logic        save_request_q;
	logic [2:0]  save_path_q;
	logic        erase_request_q;

	// sequencer outputs
	logic tick_accept;
	logic rem_start;
	logic rem_done;
	logic red_capture;
	logic clr_we;
	logic res_free;
	logic res_load;

	// next values for one tick
	mode_t                mode_b, mode_n, pending_n;
	logic [2:0]           bprev_n;
	logic                 erase_pend_n;
	logic [7:0]           dc_n;
	logic [15:0]          wc_n;
	logic [IDX_W-1:0]     si_n;
	logic [7:0]           rt_n, lt_n, rt_new, lt_new;
	logic [1:0]           ep_n;
	logic [PATH_W-1:0]    slot_n, cand_n, replay_n, slot_inc, choose_path;
	logic [NUM_PATHS-1:0] used_n;
	logic                 save_req_n, erase_req_n, play_chk_n, rec_wr;
	logic [PATH_W-1:0]    save_path_n;
	logic [ADDR_W-1:0]    tick_addr;

	// path store ports
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]        wdata_lo, wdata_hi, rdata_lo, rdata_hi;

	// read stage
	logic  end_hit;
	mode_t final_mode;
	logic [7:0] rd_duty, ld_duty;

	rem_req_t req_win, req_div;
	rem_rsp_t rsp_win, rsp_div;

	function automatic logic [7:0] to_duty(input logic [7:0] cnt, input logic [7:0] thr,
			input logic [7:0] scale, input logic [7:0] full);
		logic [15:0] prod;
		prod = 16'(cnt) * 16'(scale);
		return (cnt > thr) ? full : prod[7:0];
	endfunction

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	assign res_free = !res_valid_q || res_ready;

	always_comb begin : seq_next
		seq_d = seq_q;
		unique case (seq_q)
			SEQ_CLEAR: begin
				if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) seq_d = SEQ_IDLE;
			end
			SEQ_IDLE: begin
				if (dirty_q) begin
					if (!cfg_we) seq_d = SEQ_REDUCE;
				end else if (tick_valid) begin
					seq_d = SEQ_MEM;
				end
			end
			SEQ_REDUCE: begin
				// a config write in flight restarts the realignment
				if (cfg_we || rem_done) seq_d = SEQ_IDLE;
			end
			SEQ_MEM: begin
				if (res_free) seq_d = SEQ_IDLE;
			end
			default: seq_d = SEQ_IDLE;
		endcase
	end

	always_comb begin : seq_out
		tick_ready  = (seq_q == SEQ_IDLE) && !dirty_q;
		rem_start   = (seq_q == SEQ_IDLE) && dirty_q && !cfg_we;
		red_capture = (seq_q == SEQ_REDUCE) && rem_done && !cfg_we;
		clr_we      = (seq_q == SEQ_CLEAR);
		res_load    = (seq_q == SEQ_MEM) && res_free;
	end

	assign tick_accept = tick_valid && tick_ready;

	// ---------------------------------------------------------------
	// counter realignment after a divider or window write:
	// counters are replaced by their remainder so the wrap compare stays exact
	// ---------------------------------------------------------------
	always_comb begin
		req_win.start    = rem_start;
		req_win.dividend = window_count_q;
		req_win.divisor  = (window_ticks_q == '0) ? 16'd1 : window_ticks_q;
		req_div.start    = rem_start;
		req_div.dividend = 16'(divide_count_q);
		req_div.divisor  = (button_divide_q == '0) ? 16'd1 : 16'(button_divide_q);
	end

	oprp_rem u_rem_win (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_win),
		.rsp    (rsp_win)
	);

	oprp_rem u_rem_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_div),
		.rsp    (rsp_div)
	);

	assign rem_done = rsp_win.done && rsp_div.done;

	// ---------------------------------------------------------------
	// choose: next stored path after the candidate, wrapping once around
	// ---------------------------------------------------------------
	always_comb begin : choose_scan
		logic [PATH_W:0] p_sum;
		choose_path = candidate_path_q;
		for (int k = NUM_PATHS; k >= 1; k--) begin
			p_sum = {1'b0, candidate_path_q} + (PATH_W + 1)'(k);
			if (p_sum >= (PATH_W + 1)'(NUM_PATHS)) begin
				p_sum = p_sum - (PATH_W + 1)'(NUM_PATHS);
			end
			if (path_used_q[p_sum[PATH_W-1:0]]) choose_path = p_sum[PATH_W-1:0];
		end
	end

	assign slot_inc = (record_slot_q == PATH_W'(NUM_PATHS - 1)) ? '0 : record_slot_q + 1'b1;

	// ---------------------------------------------------------------
	// tick: button sampling, mode machine, window and index counters
	// ---------------------------------------------------------------
	always_comb begin : tick_next
		logic [7:0]       div_eff;
		logic [15:0]      win_eff;
		logic [8:0]       dc_inc;
		logic [16:0]      wc_inc;
		logic [15:0]      wc_step;
		logic [IDX_W-1:0] si_inc;

		div_eff = (button_divide_q == '0) ? 8'd1 : button_divide_q;
		win_eff = (window_ticks_q == '0) ? 16'd1 : window_ticks_q;
		dc_inc  = {1'b0, divide_count_q} + 9'd1;
		wc_inc  = {1'b0, window_count_q} + 17'd1;
		// next counts sit below their divisor, wrapping to zero when they reach it
		dc_n    = (dc_inc >= {1'b0, div_eff}) ? 8'd0 : dc_inc[7:0];
		wc_step = (wc_inc >= {1'b0, win_eff}) ? 16'd0 : wc_inc[15:0];
		si_inc  = step_index_q + 1'b1;

		mode_b       = cur_mode_q;
		pending_n    = pending_mode_q;
		bprev_n      = button_prev_q;
		erase_pend_n = erase_pending_q;
		cand_n       = candidate_path_q;
		replay_n     = replay_path_q;
		slot_n       = record_slot_q;
		save_req_n   = 1'b0;
		save_path_n  = '0;
		erase_req_n  = 1'b0;

		if (dc_n == '0) begin
			erase_req_n  = erase_pending_q;
			erase_pend_n = !btn_record && !btn_choose && !btn_select;
			// release edges, record over choose over select
			priority if (!button_prev_q[0] && btn_record) begin
				if (cur_mode_q == MODE_IDLE) pending_n = MODE_REC;
			end else if (!button_prev_q[1] && btn_choose) begin
				if (cur_mode_q == MODE_IDLE) begin
					cand_n = choose_path;
					if (path_used_q[choose_path]) pending_n = MODE_PLAY;
				end
			end else if (!button_prev_q[2] && btn_select) begin
				unique case (cur_mode_q)
					MODE_IDLE: begin
						replay_n = candidate_path_q;
						mode_b   = pending_mode_q;
					end
					MODE_REC: begin
						mode_b      = MODE_IDLE;
						save_req_n  = 1'b1;
						save_path_n = record_slot_q;
						slot_n      = slot_inc;
						cand_n      = '0;
						pending_n   = MODE_IDLE;
					end
					default: mode_b = MODE_IDLE;
				endcase
			end else begin
				mode_b = cur_mode_q;
			end
			bprev_n = {btn_select, btn_choose, btn_record};
		end

		mode_n     = mode_b;
		wc_n       = window_count_q;
		si_n       = step_index_q;
		rt_n       = right_ticks_q;
		lt_n       = left_ticks_q;
		ep_n       = encoder_prev_q;
		used_n     = path_used_q;
		play_chk_n = 1'b0;
		rec_wr     = 1'b0;
		rt_new     = right_ticks_q + 8'(enc_right_level != encoder_prev_q[0]);
		lt_new     = left_ticks_q + 8'(enc_left_level != encoder_prev_q[1]);
		tick_addr  = {replay_n, si_n};

		if (!obstacle) begin
			if (mode_b == MODE_PLAY) begin
				wc_n = wc_step;
				if (wc_step == '0) si_n = si_inc;
				// end mark check and duties come from the read stage
				play_chk_n = 1'b1;
				tick_addr  = {replay_n, si_n};
			end else if (mode_b != MODE_REC) begin
				wc_n = 16'd1;
				si_n = '0;
				rt_n = '0;
				lt_n = '0;
			end else begin
				wc_n = wc_step;
				ep_n = {enc_left_level, enc_right_level};
				rt_n = rt_new;
				lt_n = lt_new;
				tick_addr = {slot_n, step_index_q};
				if (wc_step == '0) begin
					rec_wr = 1'b1;
					if (step_index_q == '0) used_n[slot_n] = (rt_new != END_MARK);
					si_n = si_inc;
					if (9'(si_inc) > 9'(record_limit_q)) begin
						slot_n    = slot_inc;
						mode_n    = MODE_IDLE;
						pending_n = MODE_IDLE;
						si_n      = '0;
					end
					rt_n = '0;
					lt_n = '0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// path store: lower half holds right counts, upper half left counts
	// ---------------------------------------------------------------
	assign mem_we   = clr_we || (tick_accept && rec_wr);
	assign mem_re   = tick_accept && play_chk_n;
	assign mem_addr = clr_we ? clr_addr_q : tick_addr;
	assign wdata_lo = clr_we ? END_MARK : rt_new;
	assign wdata_hi = clr_we ? END_MARK : lt_new;

	oprp_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (8)
	) u_store_lo (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (wdata_lo),
		.rdata (rdata_lo)
	);

	oprp_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (8)
	) u_store_hi (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (wdata_hi),
		.rdata (rdata_hi)
	);

	// ---------------------------------------------------------------
	// read stage: playback ends on the end mark, counts become duties
	// ---------------------------------------------------------------
	always_comb begin
		end_hit    = play_chk_s1 && (rdata_lo == END_MARK);
		final_mode = end_hit ? MODE_IDLE : cur_mode_q;
		rd_duty    = '0;
		ld_duty    = '0;
		if (play_chk_s1 && !end_hit) begin
			rd_duty = to_duty(rdata_lo, turn_threshold_q, duty_scale_q, duty_full_q);
			ld_duty = to_duty(rdata_hi, turn_threshold_q, duty_scale_q, duty_full_q);
		end
	end

	// ---------------------------------------------------------------
	// state registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ticks_q   <= RST_WINDOW_TICKS;
			button_divide_q  <= RST_BUTTON_DIVIDE;
			record_limit_q   <= RST_RECORD_LIMIT;
			turn_threshold_q <= RST_TURN_THRESHOLD;
			duty_scale_q     <= RST_DUTY_SCALE;
			duty_full_q      <= RST_DUTY_FULL;
			seq_q            <= SEQ_CLEAR;
			dirty_q          <= 1'b0;
			clr_addr_q       <= '0;
			cur_mode_q       <= MODE_IDLE;
			pending_mode_q   <= MODE_IDLE;
			button_prev_q    <= 3'b111;
			erase_pending_q  <= 1'b0;
			divide_count_q   <= '0;
			window_count_q   <= 16'd1;
			step_index_q     <= '0;
			right_ticks_q    <= '0;
			left_ticks_q     <= '0;
			encoder_prev_q   <= '0;
			record_slot_q    <= '0;
			candidate_path_q <= '0;
			replay_path_q    <= '0;
			path_used_q      <= '0;
			play_chk_s1      <= 1'b0;
			save_req_s1      <= 1'b0;
			save_path_s1     <= '0;
			erase_req_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WINDOW_TICKS:   window_ticks_q   <= cfg_wdata;
					CFG_BUTTON_DIVIDE:  button_divide_q  <= cfg_wdata[7:0];
					CFG_RECORD_LIMIT:   record_limit_q   <= cfg_wdata[7:0];
					CFG_TURN_THRESHOLD: turn_threshold_q <= cfg_wdata[7:0];
					CFG_DUTY_SCALE:     duty_scale_q     <= cfg_wdata[7:0];
					CFG_DUTY_FULL:      duty_full_q      <= cfg_wdata[7:0];
					default: ;
				endcase
			end

			if (cfg_we && (cfg_index == CFG_WINDOW_TICKS || cfg_index == CFG_BUTTON_DIVIDE)) begin
				dirty_q <= 1'b1;
			end else if (red_capture) begin
				dirty_q <= 1'b0;
			end

			seq_q <= seq_d;

			if (clr_we) clr_addr_q <= clr_addr_q + 1'b1;

			if (red_capture) begin
				window_count_q <= rsp_win.remainder;
				divide_count_q <= rsp_div.remainder[7:0];
			end

			if (tick_accept) begin
				cur_mode_q       <= mode_n;
				pending_mode_q   <= pending_n;
				button_prev_q    <= bprev_n;
				erase_pending_q  <= erase_pend_n;
				divide_count_q   <= dc_n;
				window_count_q   <= wc_n;
				step_index_q     <= si_n;
				right_ticks_q    <= rt_n;
				left_ticks_q     <= lt_n;
				encoder_prev_q   <= ep_n;
				record_slot_q    <= slot_n;
				candidate_path_q <= cand_n;
				replay_path_q    <= replay_n;
				path_used_q      <= used_n;
				play_chk_s1      <= play_chk_n;
				save_req_s1      <= save_req_n;
				save_path_s1     <= save_path_n;
				erase_req_s1     <= erase_req_n;
			end else if (res_load && end_hit) begin
				cur_mode_q <= MODE_IDLE;
			end
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			op_state_q      <= final_mode;
			active_path_q   <= 3'(replay_path_q);
			path_index_q    <= 8'(step_index_q);
			right_duty_q    <= rd_duty;
			left_duty_q     <= ld_duty;
			save_request_q  <= save_req_s1;
			save_path_q     <= 3'(save_path_s1);
			erase_request_q <= erase_req_s1;
		end
	end

	assign res_valid     = res_valid_q;
	assign op_state      = op_state_q;
	assign active_path   = active_path_q;
	assign path_index    = path_index_q;
	assign right_duty    = right_duty_q;
	assign left_duty     = left_duty_q;
	assign save_request  = save_request_q;
	assign save_path     = save_path_q;
	assign erase_request = erase_request_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
`ifndef ASSERT_OFF
	a_no_tick_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SEQ_CLEAR) |-> !tick_ready)
		else $error("tick taken during store clearing pass");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("path store read and write in the same cycle");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && tick_ready && !res_valid) |-> ##2 res_valid)
		else $error("result not presented two cycles after tick transfer");

	a_save_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && save_request) |-> (op_state == MODE_IDLE))
		else $error("save request outside idle mode");
`endif

endmodule

// ===== test/testbench.sv =====
// self-checking testbench of odometry_path_record_playback_unit: scoreboard class with its own
// predictor of the path unit, tick and status drivers, directed and random stimulus
// depends on oprp_pkg and the rtl of the unit
`timescale 1ns / 100ps

module testbench;
	import oprp_pkg::*;

	// one tick as it crosses the tick channel, field order matches the port order
	typedef struct packed {
		logic btn_record;
		logic btn_choose;
		logic btn_select;
		logic enc_right;
		logic enc_left;
		logic obstacle;
	} tick_t;

	// one status transfer on the result channel
	typedef struct packed {
		logic [1:0] op_state;
		logic [2:0] active_path;
		logic [7:0] path_index;
		logic [7:0] right_duty;
		logic [7:0] left_duty;
		logic       save_request;
		logic [2:0] save_path;
		logic       erase_request;
	} status_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_EVERY_THIRD,
		RX_SPARSE
	} rx_pattern_t;

	// button levels as {select, choose, record}, 0 means pressed
	localparam logic [2:0] BTN_NONE = 3'b111;
	localparam logic [2:0] BTN_REC  = 3'b110;
	localparam logic [2:0] BTN_CHO  = 3'b101;
	localparam logic [2:0] BTN_SEL  = 3'b011;
	localparam logic [2:0] BTN_ALL  = 3'b000;

	localparam int CLEAR_CYCLES = 2100;    // clearing pass of the path store after reset
	localparam int SETTLE       = 32;      // counter realignment after a register write
	localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 300000;

	// scoreboard: predicts the status of each accepted tick and checks the status transfers
	class odometry_scoreboard;
		logic [15:0] window_ticks;
		logic [7:0]  button_divide, record_limit, turn_threshold, duty_scale, duty_full;
		logic [7:0]  store [NUM_PATHS * PATH_BYTES];
		mode_t       cur_mode, pending_mode;
		logic [2:0]  btn_prev;
		logic        erase_armed;
		int unsigned divide_count, window_count, step;
		logic [7:0]  right_ticks, left_ticks;
		logic [1:0]  enc_prev;
		int unsigned record_slot, candidate, replay;
		status_t     status_due[$];
		int          failures;

		function new();
			window_ticks   = RST_WINDOW_TICKS;
			button_divide  = RST_BUTTON_DIVIDE;
			record_limit   = RST_RECORD_LIMIT;
			turn_threshold = RST_TURN_THRESHOLD;
			duty_scale     = RST_DUTY_SCALE;
			duty_full      = RST_DUTY_FULL;
			foreach (store[a])
				store[a] = END_MARK;
			cur_mode     = MODE_IDLE;
			pending_mode = MODE_IDLE;
			btn_prev     = 3'b111;
			erase_armed  = 1'b0;
			divide_count = 0;
			window_count = 1;
			step         = 0;
			right_ticks  = 8'd0;
			left_ticks   = 8'd0;
			enc_prev     = 2'b00;
			record_slot  = 0;
			candidate    = 0;
			replay       = 0;
			failures     = 0;
		endfunction

		function int unsigned slot_addr(int unsigned path, int unsigned off);
			return (path % NUM_PATHS) * PATH_BYTES + (off % PATH_BYTES);
		endfunction

		function logic [7:0] duty_of(logic [7:0] count);
			logic [15:0] prod;
			if (count > turn_threshold)
				return duty_full;
			prod = count * duty_scale;
			return prod[7:0];
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				CFG_WINDOW_TICKS:   window_ticks   = data;
				CFG_BUTTON_DIVIDE:  button_divide  = data[7:0];
				CFG_RECORD_LIMIT:   record_limit   = data[7:0];
				CFG_TURN_THRESHOLD: turn_threshold = data[7:0];
				CFG_DUTY_SCALE:     duty_scale     = data[7:0];
				CFG_DUTY_FULL:      duty_full      = data[7:0];
				default: ;
			endcase
		endfunction

		// notes an accepted tick and queues the status it must produce
		function void tick_taken(tick_t t);
			int unsigned div, win, k;
			logic [2:0]  btn, rel;
			status_t     s;
			s   = '0;
			btn = {t.btn_select, t.btn_choose, t.btn_record};
			div = (button_divide == 8'd0) ? 1 : button_divide;
			win = (window_ticks == 16'd0) ? 1 : window_ticks;

			// button sampling and mode machine
			divide_count = (divide_count + 1) % div;
			if (divide_count == 0) begin
				s.erase_request = erase_armed;
				erase_armed = (btn == BTN_ALL);
				rel = ~btn_prev & btn;
				if (rel[0]) begin
					if (cur_mode == MODE_IDLE)
						pending_mode = MODE_REC;
				end else if (rel[1]) begin
					if (cur_mode == MODE_IDLE) begin
						for (k = 0; k < NUM_PATHS; k++) begin
							candidate = (candidate + 1) % NUM_PATHS;
							if (store[slot_addr(candidate, 0)] != END_MARK)
								break;
						end
						if (store[slot_addr(candidate, 0)] != END_MARK)
							pending_mode = MODE_PLAY;
					end
				end else if (rel[2]) begin
					if (cur_mode == MODE_IDLE) begin
						replay   = candidate;
						cur_mode = pending_mode;
					end else if (cur_mode == MODE_REC) begin
						cur_mode       = MODE_IDLE;
						s.save_request = 1'b1;
						s.save_path    = 3'(record_slot);
						record_slot    = (record_slot + 1) % NUM_PATHS;
						candidate      = 0;
						pending_mode   = MODE_IDLE;
					end else begin
						cur_mode = MODE_IDLE;
					end
				end
				btn_prev = btn;
			end

			// path logic, frozen by an obstacle
			if (!t.obstacle) begin
				if (cur_mode == MODE_PLAY) begin
					window_count = (window_count + 1) % win;
					if (window_count == 0)
						step = (step + 1) % INDEX_WRAP;
					if (store[slot_addr(replay, step)] == END_MARK)
						cur_mode = MODE_IDLE;
				end else if (cur_mode != MODE_REC) begin
					window_count = 1;
					step         = 0;
					right_ticks  = 8'd0;
					left_ticks   = 8'd0;
				end else begin
					window_count = (window_count + 1) % win;
					if (t.enc_right != enc_prev[0])
						right_ticks++;
					if (t.enc_left != enc_prev[1])
						left_ticks++;
					enc_prev = {t.enc_left, t.enc_right};
					if (window_count == 0) begin
						store[slot_addr(record_slot, step)]              = right_ticks;
						store[slot_addr(record_slot, step + HALF_BYTES)] = left_ticks;
						step = (step + 1) % INDEX_WRAP;
						if (step > record_limit) begin
							record_slot  = (record_slot + 1) % NUM_PATHS;
							cur_mode     = MODE_IDLE;
							pending_mode = MODE_IDLE;
							step         = 0;
						end
						right_ticks = 8'd0;
						left_ticks  = 8'd0;
					end
				end
				if (cur_mode == MODE_PLAY) begin
					s.right_duty = duty_of(store[slot_addr(replay, step)]);
					s.left_duty  = duty_of(store[slot_addr(replay, step + HALF_BYTES)]);
				end
			end

			s.op_state    = cur_mode;
			s.active_path = 3'(replay);
			s.path_index  = 8'(step);
			status_due.push_back(s);
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				failures++;
			end
		endfunction

		// compares a status transfer with the oldest prediction
		function void status_seen(status_t got);
			status_t want;
			if (status_due.size() == 0) begin
				$error("status transfer with no prediction pending");
				failures++;
				return;
			end
			want = status_due.pop_front();
			check_field("op_state", want.op_state, got.op_state);
			check_field("active_path", want.active_path, got.active_path);
			check_field("path_index", want.path_index, got.path_index);
			check_field("right_duty", want.right_duty, got.right_duty);
			check_field("left_duty", want.left_duty, got.left_duty);
			check_field("save_request", want.save_request, got.save_request);
			check_field("save_path", want.save_path, got.save_path);
			check_field("erase_request", want.erase_request, got.erase_request);
		endfunction
	endclass

	// every input starts at a known value: buttons released, no obstacle
	logic                 clk             = 1'b0;
	logic                 arst_n          = 1'b0;
	logic                 cfg_we          = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index       = '0;
	logic [15:0]          cfg_wdata       = '0;
	logic                 tick_valid      = 1'b0;
	logic                 tick_ready;
	logic                 btn_record      = 1'b1;
	logic                 btn_choose      = 1'b1;
	logic                 btn_select      = 1'b1;
	logic                 enc_right_level = 1'b0;
	logic                 enc_left_level  = 1'b0;
	logic                 obstacle        = 1'b0;
	logic                 res_valid;
	logic                 res_ready       = 1'b0;
	logic [1:0]           op_state;
	logic [2:0]           active_path;
	logic [7:0]           path_index;
	logic [7:0]           right_duty;
	logic [7:0]           left_duty;
	logic                 save_request;
	logic [2:0]           save_path;
	logic                 erase_request;

	odometry_scoreboard scoreboard;

	int unsigned burst_left = 0;    // ticks left in the current sender burst
	int unsigned items_sent = 0;
	int unsigned cur_win    = 1;    // window and divider in force, for shaping gestures
	int unsigned cur_div    = 1;
	bit          hold_off_request = 1'b0;
	int unsigned hold_left  = 0;
	int unsigned stall_left = 0;
	rx_pattern_t stall_mode = RX_OPEN;
	int          cycle_count = 0;

	odometry_path_record_playback_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.tick_valid      (tick_valid),
		.tick_ready      (tick_ready),
		.btn_record      (btn_record),
		.btn_choose      (btn_choose),
		.btn_select      (btn_select),
		.enc_right_level (enc_right_level),
		.enc_left_level  (enc_left_level),
		.obstacle        (obstacle),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.op_state        (op_state),
		.active_path     (active_path),
		.path_index      (path_index),
		.right_duty      (right_duty),
		.left_duty       (left_duty),
		.save_request    (save_request),
		.save_path       (save_path),
		.erase_request   (erase_request)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// status channel: every transfer goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			scoreboard.status_seen(status_t'({op_state, active_path, path_index, right_duty,
				left_duty, save_request, save_path, erase_request}));
	end

	// receiver: random stall patterns, plus a long hold-off on request from the stimulus
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else if (hold_off_request) begin
			hold_off_request = 1'b0;
			hold_left = HOLD_CYCLES;
			res_ready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = rx_pattern_t'($urandom_range(0, 3));
				stall_left = $urandom_range(8, 64);
			end
			stall_left--;
			case (stall_mode)
				RX_OPEN:        res_ready <= 1'b1;
				RX_COIN:        res_ready <= 1'($urandom_range(0, 1));
				RX_EVERY_THIRD: res_ready <= (stall_left % 3 == 0);
				RX_SPARSE:      res_ready <= ($urandom_range(0, 7) == 0);
				default:        res_ready <= 1'b1;
			endcase
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// offers one tick; the sender works in bursts with random gaps in between
	task automatic offer(input logic [2:0] btn, input logic er, input logic el, input logic ob);
		int unsigned gap;
		tick_t       t;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(40, 120);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(0, 6);
			end
			if (gap != 0) begin
				tick_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		t.btn_record = btn[0];
		t.btn_choose = btn[1];
		t.btn_select = btn[2];
		t.enc_right  = er;
		t.enc_left   = el;
		t.obstacle   = ob;
		tick_valid      <= 1'b1;
		btn_record      <= btn[0];
		btn_choose      <= btn[1];
		btn_select      <= btn[2];
		enc_right_level <= er;
		enc_left_level  <= el;
		obstacle        <= ob;
		@(posedge clk);
		while (!tick_ready) @(posedge clk);
		scoreboard.tick_taken(t);
		burst_left--;
		items_sent++;
	endtask

	// n ticks with fixed buttons, random wheel encoders and a rare obstacle
	task automatic hold(input logic [2:0] btn, input int unsigned n);
		repeat (n)
			offer(btn, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				$urandom_range(0, 31) == 0);
	endtask

	// a button held for one sample and released for the next
	task automatic press(input logic [2:0] btn);
		hold(btn, cur_div);
		hold(BTN_NONE, cur_div);
	endtask

	// select until the unit is back in idle
	task automatic settle_idle();
		while (scoreboard.cur_mode != MODE_IDLE)
			press(BTN_SEL);
	endtask

	// sender stops until every predicted status has come back
	task automatic drain();
		tick_valid <= 1'b0;
		while (scoreboard.status_due.size() != 0) @(posedge clk);
	endtask

	task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		scoreboard.set_reg(idx, data);
	endtask

	task automatic set_config(input logic [15:0] win, input logic [7:0] div,
		input logic [7:0] lim, input logic [7:0] thr, input logic [7:0] scale,
		input logic [7:0] full);
		drain();
		load_reg(CFG_WINDOW_TICKS, win);
		load_reg(CFG_BUTTON_DIVIDE, 16'(div));
		load_reg(CFG_RECORD_LIMIT, 16'(lim));
		load_reg(CFG_TURN_THRESHOLD, 16'(thr));
		load_reg(CFG_DUTY_SCALE, 16'(scale));
		load_reg(CFG_DUTY_FULL, 16'(full));
		cur_win = win;
		cur_div = div;
	endtask

	// mostly record-then-replay sessions with random content, some noise and broken gestures
	task automatic session();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			settle_idle();
			press(BTN_REC);
			press(BTN_SEL);
			hold(BTN_NONE, cur_win * $urandom_range(1, 6) + $urandom_range(0, 2));
			// sometimes leave it to the record limit
			if ($urandom_range(0, 4) != 0)
				press(BTN_SEL);
			repeat ($urandom_range(1, 3)) press(BTN_CHO);
			press(BTN_SEL);
			hold(BTN_NONE, cur_win * $urandom_range(1, 8));
			if ($urandom_range(0, 1) != 0)
				press(BTN_SEL);
		end else if (pick == 7) begin
			repeat ($urandom_range(4, 16)) hold(3'($urandom_range(0, 7)), 1);
		end else if (pick == 8) begin
			// all three held, then released together
			hold(BTN_ALL, cur_div);
			hold(BTN_NONE, 2 * cur_div);
		end else begin
			case ($urandom_range(0, 2))
				0:       press(BTN_REC);
				1:       press(BTN_CHO);
				default: press(BTN_SEL);
			endcase
		end
	endtask

	task automatic run_sessions(input int unsigned budget);
		int unsigned start;
		start = items_sent;
		while (items_sent - start < budget)
			session();
	endtask

	initial begin
		scoreboard = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (CLEAR_CYCLES) @(posedge clk);

		// directed: sample every tick, short windows
		set_config(16'd2, 8'd1, 8'd8, RST_TURN_THRESHOLD, RST_DUTY_SCALE, RST_DUTY_FULL);
		offer(BTN_CHO, 1'b0, 1'b0, 1'b0);     // choose with an empty store
		offer(BTN_NONE, 1'b0, 1'b0, 1'b0);
		offer(BTN_REC, 1'b0, 1'b0, 1'b0);
		offer(BTN_NONE, 1'b0, 1'b0, 1'b0);
		offer(BTN_SEL, 1'b0, 1'b0, 1'b0);
		offer(BTN_NONE, 1'b1, 1'b0, 1'b0);     // recording starts, right line toggles
		offer(BTN_NONE, 1'b0, 1'b1, 1'b0);
		offer(BTN_NONE, 1'b1, 1'b1, 1'b1);     // obstacle freezes the window
		offer(BTN_NONE, 1'b1, 1'b1, 1'b1);
		offer(BTN_NONE, 1'b0, 1'b0, 1'b0);
		offer(BTN_NONE, 1'b1, 1'b1, 1'b0);
		offer(BTN_SEL, 1'b0, 1'b0, 1'b0);      // stop and raise the save request
		offer(BTN_NONE, 1'b0, 1'b0, 1'b0);
		offer(BTN_CHO, 1'b0, 1'b0, 1'b0);      // scan wraps around to the new path
		offer(BTN_NONE, 1'b0, 1'b0, 1'b0);
		offer(BTN_SEL, 1'b0, 1'b0, 1'b0);      // replay until the end mark
		offer(BTN_NONE, 1'b0, 1'b0, 1'b0);
		offer(BTN_NONE, 1'b0, 1'b0, 1'b1);
		offer(BTN_NONE, 1'b0, 1'b0, 1'b0);
		offer(BTN_NONE, 1'b0, 1'b0, 1'b0);
		offer(BTN_ALL, 1'b0, 1'b0, 1'b0);      // all held arms the erase request
		offer(BTN_ALL, 1'b0, 1'b0, 1'b0);
		offer(BTN_NONE, 1'b0, 1'b0, 1'b0);     // three releases at once, record wins

		// low extremes: one-tick windows, limit of one step, any nonzero count is a turn
		set_config(16'd1, 8'd1, 8'd1, 8'd0, 8'd255, 8'd255);
		run_sessions(60);

		// one long recording that wraps the step index, then replay of whatever is chosen
		set_config(16'd1, 8'd1, 8'd255, 8'd255, 8'd0, 8'd0);
		settle_idle();
		press(BTN_REC);
		press(BTN_SEL);
		hold(BTN_NONE, 280);
		press(BTN_SEL);
		press(BTN_CHO);
		press(BTN_SEL);
		hold(BTN_NONE, 40);
		settle_idle();

		// high extremes: longest window and divider, random held buttons
		set_config(16'd65535, 8'd255, 8'd200, 8'd3, 8'd17, 8'd200);
		repeat (3) hold(3'($urandom_range(0, 7)), 40);

		// random settings; the second one starts under a long receiver hold-off
		for (int p = 0; p < 3; p++) begin
			set_config(16'($urandom_range(1, 5)), 8'($urandom_range(1, 3)),
				8'($urandom_range(1, 12)), 8'($urandom_range(0, 10)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			if (p == 1)
				hold_off_request = 1'b1;
			run_sessions(60);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (scoreboard.failures == 0 && scoreboard.status_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
sv/oprp_pkg.sv
sv/oprp_ram.sv
sv/oprp_rem.sv
sv/odometry_path_record_playback_unit.sv
test/testbench.sv
